FILE: sv/gcr62_pkg.sv
// Shared types, constants and lookup functions of the 6-and-2 GCR track formatter.
// Used by every module of the block; depends on nothing.
package gcr62_pkg;

  localparam int unsigned SECTORS         = 16;
  localparam int unsigned SECTOR_BYTES    = 256;
  localparam int unsigned LEAD_GAP_LEN    = 48;
  localparam int unsigned ADDRESS_GAP_LEN = 6;
  localparam int unsigned SECTOR_GAP_LEN  = 27;

  localparam int unsigned SEC_W   = $clog2(SECTORS);
  localparam int unsigned OFS_W   = $clog2(SECTOR_BYTES);
  localparam int unsigned ADDR_W  = SEC_W + OFS_W;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned FIELD_W = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 14;

  localparam int unsigned AUX_LEN    = 86;
  localparam int unsigned NIBBLE_LEN = 342;
  localparam int unsigned DATA_OFS   = 14 + ADDRESS_GAP_LEN;
  localparam int unsigned FRAME_LEN  = 363 + ADDRESS_GAP_LEN + SECTOR_GAP_LEN;
  localparam int unsigned BODY_END   = LEAD_GAP_LEN + SECTORS * FRAME_LEN;

  // Byte offsets of the parts of one sector frame.
  localparam logic [FIELD_W-1:0] F_ADDR_FIELD = FIELD_W'(3);
  localparam logic [FIELD_W-1:0] F_ADDR_EPI   = FIELD_W'(11);
  localparam logic [FIELD_W-1:0] F_ADDR_GAP   = FIELD_W'(14);
  localparam logic [FIELD_W-1:0] F_DATA_PRO   = FIELD_W'(DATA_OFS);
  localparam logic [FIELD_W-1:0] F_NIBBLE     = FIELD_W'(DATA_OFS + 3);
  localparam logic [FIELD_W-1:0] F_CHECK      = FIELD_W'(DATA_OFS + 3 + NIBBLE_LEN);
  localparam logic [FIELD_W-1:0] F_DATA_EPI   = FIELD_W'(DATA_OFS + 4 + NIBBLE_LEN);
  localparam logic [FIELD_W-1:0] F_SECTOR_GAP = FIELD_W'(DATA_OFS + 7 + NIBBLE_LEN);
  localparam logic [FIELD_W-1:0] F_LAST       = FIELD_W'(FRAME_LEN - 1);

  localparam logic [POS_W-1:0] P_LEAD_END = POS_W'(LEAD_GAP_LEN);
  localparam logic [POS_W-1:0] P_BODY_END = POS_W'(BODY_END);

  localparam logic [POS_W-1:0] TRACK_LENGTH_RESET  = POS_W'(6400);
  localparam logic [7:0]       VOLUME_NUMBER_RESET = 8'hFE;

  localparam logic [7:0] GAP_BYTE  = 8'hFF;
  localparam logic [7:0] ADDR_MARK = 8'hAA;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_PULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_NUMBER = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] byte_index;
    logic [7:0]        data_byte;
    logic [7:0]        track_id;
  } in_item_t;

  typedef struct packed {
    logic [7:0] track_byte;
    logic       last_of_track;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] track_length;
    logic [7:0]       volume_number;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  localparam logic [7:0] GCR_TABLE [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  localparam logic [7:0] SKEW_TABLE [16] = '{
    8'h00, 8'h0D, 8'h0B, 8'h09, 8'h07, 8'h05, 8'h03, 8'h01,
    8'h0E, 8'h0C, 8'h0A, 8'h08, 8'h06, 8'h04, 8'h02, 8'h0F
  };

  function automatic logic [1:0] swap2(input logic [1:0] b);
    return {b[0], b[1]};
  endfunction

  function automatic logic [7:0] addr_pro_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hD5;
      2'd1:    b = 8'hAA;
      default: b = 8'h96;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] data_pro_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hD5;
      2'd1:    b = 8'hAA;
      default: b = 8'hAD;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] epilogue_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hDE;
      2'd1:    b = 8'hAA;
      default: b = 8'hEB;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/gcr62_floppy_track_formatter.sv
// Top level of the 16-sector 6-and-2 GCR track formatter: configuration registers,
// output register, sector buffer and track sequencer. Depends on gcr62_pkg.
//
// Usage: the input channel carries one beat per action. A load beat writes one
// byte into the 4096-byte sector buffer, a start beat sets the track number and
// rewinds the track, and a pull beat asks for the next disk byte. Each pull
// during an active track yields one beat on the output channel, with
// last_of_track set on the final byte; pulls after the end yield nothing.
// The configuration channel writes track_length (index 0) and volume_number
// (index 1) and is always ready; the user must see that it is written only
// while the block is idle, which the block does not enforce. A pull of a gap,
// mark or address byte passes the sequencer result register, then the output
// register; the next beat is accepted once the byte moves on. A data-field
// byte needs one buffer read or, for the auxiliary bytes that gather bit pairs
// from three sector bytes, three reads on the single buffer read port. The
// output register lets the next beat be accepted while a byte waits; a second
// byte is held in the sequencer until the receiver takes the first.
// Reset clears the control state and restores track_length 6400 and volume
// 254; the sector buffer is not cleared and holds garbage until loaded.
module gcr62_floppy_track_formatter import gcr62_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg_q;
  ram_req_t   ram_req;
  logic [7:0] ram_rdata;
  logic       res_valid;
  logic       res_ready;
  out_item_t  res;
  logic       out_valid_q;
  out_item_t  out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.track_length  <= TRACK_LENGTH_RESET;
      cfg_q.volume_number <= VOLUME_NUMBER_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TRACK_LENGTH:  cfg_q.track_length  <= cfg_data_i[POS_W-1:0];
        CFG_VOLUME_NUMBER: cfg_q.volume_number <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  gcr62_sector_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  gcr62_track_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/gcr62_sector_ram.sv
// Sector buffer: 4096 x 8 synchronous RAM, one write port and one registered read port.
// Depends on gcr62_pkg for the address width and the request struct.
module gcr62_sector_ram import gcr62_pkg::*; (
  input  logic       clk_i,
  input  ram_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [SECTORS * SECTOR_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/gcr62_track_seq.sv
// Track sequencer: decodes input beats, walks the track layout and builds each disk byte,
// reading the sector buffer for the 6-and-2 data field. Depends on gcr62_pkg.
module gcr62_track_seq import gcr62_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  input  cfg_t       cfg_i,
  output ram_req_t   ram_req_o,
  input  logic [7:0] ram_rdata_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output out_item_t  res_o
);

  typedef enum logic [2:0] {S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_EMIT} state_e;

  state_e             state_q;
  logic               active_q;
  logic [POS_W-1:0]   pos_q;
  logic [SEC_W-1:0]   sector_q;
  logic [FIELD_W-1:0] field_q;
  logic [5:0]         prev_q;
  logic [7:0]         track_q;
  logic [SEC_W-1:0]   rd_sec_q;
  logic [OFS_W-1:0]   rd_idx_q;
  logic               rd_aux_q;
  logic               rd_first_q;
  logic [3:0]         v_lo_q;
  out_item_t          res_q;

  logic               in_body;
  logic               pull_ok;
  logic               last_now;
  logic               need_read;
  logic               aux_now;
  logic [FIELD_W-1:0] f_addr;
  logic [FIELD_W-1:0] f_aepi;
  logic [FIELD_W-1:0] f_dpro;
  logic [FIELD_W-1:0] f_depi;
  logic [FIELD_W-1:0] d_now;
  logic [FIELD_W-1:0] d_hi;
  logic [OFS_W-1:0]   i_now;
  logic [7:0]         addr_field;
  logic [7:0]         direct_byte;
  logic [5:0]         v_full;
  logic [5:0]         prev_eff;
  logic [7:0]         nib_byte;

  assign in_ready_o = (state_q == S_IDLE);

  assign in_body  = (pos_q >= P_LEAD_END) && (pos_q < P_BODY_END);
  assign pull_ok  = active_q && (pos_q < cfg_i.track_length);
  assign last_now = ({1'b0, pos_q} + (POS_W + 1)'(1)) >= {1'b0, cfg_i.track_length};

  assign f_addr = field_q - F_ADDR_FIELD;
  assign f_aepi = field_q - F_ADDR_EPI;
  assign f_dpro = field_q - F_DATA_PRO;
  assign f_depi = field_q - F_DATA_EPI;
  assign d_now  = field_q - F_NIBBLE;
  assign d_hi   = d_now - FIELD_W'(AUX_LEN);

  assign need_read = in_body && (field_q >= F_NIBBLE) && (field_q < F_CHECK);
  assign aux_now   = (d_now < FIELD_W'(AUX_LEN));
  assign i_now     = aux_now ? d_now[OFS_W-1:0] : d_hi[OFS_W-1:0];

  // Address field: volume, track, skewed sector, check, each as odd then even bits.
  always_comb begin
    case (f_addr[2:1])
      2'd0:    addr_field = cfg_i.volume_number;
      2'd1:    addr_field = track_q;
      2'd2:    addr_field = SKEW_TABLE[sector_q];
      default: addr_field = cfg_i.volume_number ^ track_q ^ SKEW_TABLE[sector_q];
    endcase
    if (!f_addr[0]) begin
      addr_field = addr_field >> 1;
    end
    addr_field = addr_field | ADDR_MARK;
  end

  always_comb begin
    direct_byte = GAP_BYTE;
    if (in_body) begin
      if (field_q < F_ADDR_FIELD) begin
        direct_byte = addr_pro_byte(field_q[1:0]);
      end else if (field_q < F_ADDR_EPI) begin
        direct_byte = addr_field;
      end else if (field_q < F_ADDR_GAP) begin
        direct_byte = epilogue_byte(f_aepi[1:0]);
      end else if (field_q < F_DATA_PRO) begin
        direct_byte = GAP_BYTE;
      end else if (field_q < F_NIBBLE) begin
        direct_byte = data_pro_byte(f_dpro[1:0]);
      end else if (field_q < F_CHECK) begin
        direct_byte = GAP_BYTE;
      end else if (field_q < F_DATA_EPI) begin
        direct_byte = GCR_TABLE[prev_q];
      end else if (field_q < F_SECTOR_GAP) begin
        direct_byte = epilogue_byte(f_depi[1:0]);
      end
    end
  end

  // Auxiliary values gather three bit pairs; the rest are the top six bits of one byte.
  assign v_full   = rd_aux_q ? {swap2(ram_rdata_i[1:0]), v_lo_q} : ram_rdata_i[7:2];
  assign prev_eff = rd_first_q ? 6'd0 : prev_q;
  assign nib_byte = GCR_TABLE[v_full ^ prev_eff];

  always_comb begin
    ram_req_o.we    = in_valid_i && (state_q == S_IDLE) && (in_data_i.action == ACT_LOAD);
    ram_req_o.waddr = in_data_i.byte_index;
    ram_req_o.wdata = in_data_i.data_byte;
    case (state_q)
      S_RD_A:  ram_req_o.raddr = {rd_sec_q, rd_idx_q + OFS_W'(AUX_LEN)};
      S_RD_B:  ram_req_o.raddr = {rd_sec_q, rd_idx_q + OFS_W'(2 * AUX_LEN)};
      default: ram_req_o.raddr = {sector_q, i_now};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      active_q   <= 1'b0;
      pos_q      <= '0;
      sector_q   <= '0;
      field_q    <= '0;
      prev_q     <= '0;
      track_q    <= '0;
      rd_sec_q   <= '0;
      rd_idx_q   <= '0;
      rd_aux_q   <= 1'b0;
      rd_first_q <= 1'b0;
      v_lo_q     <= '0;
      res_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (in_data_i.action)
              ACT_START: begin
                track_q  <= in_data_i.track_id;
                pos_q    <= '0;
                sector_q <= '0;
                field_q  <= '0;
                prev_q   <= '0;
                active_q <= 1'b1;
              end
              ACT_PULL: begin
                if (!pull_ok) begin
                  active_q <= 1'b0;
                end else begin
                  pos_q <= pos_q + POS_W'(1);
                  if (in_body) begin
                    if (field_q == F_LAST) begin
                      field_q  <= '0;
                      sector_q <= sector_q + SEC_W'(1);
                    end else begin
                      field_q <= field_q + FIELD_W'(1);
                    end
                  end
                  res_q.last_of_track <= last_now;
                  if (last_now) begin
                    active_q <= 1'b0;
                  end
                  if (need_read) begin
                    rd_sec_q   <= sector_q;
                    rd_idx_q   <= i_now;
                    rd_aux_q   <= aux_now;
                    rd_first_q <= (d_now == '0);
                    state_q    <= S_RD_A;
                  end else begin
                    res_q.track_byte <= direct_byte;
                    state_q          <= S_EMIT;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD_A: begin
          if (rd_aux_q) begin
            v_lo_q[1:0] <= swap2(ram_rdata_i[1:0]);
            state_q     <= S_RD_B;
          end else begin
            prev_q           <= v_full;
            res_q.track_byte <= nib_byte;
            state_q          <= S_EMIT;
          end
        end
        S_RD_B: begin
          v_lo_q[3:2] <= swap2(ram_rdata_i[1:0]);
          state_q     <= S_RD_C;
        end
        S_RD_C: begin
          prev_q           <= v_full;
          res_q.track_byte <= nib_byte;
          state_q          <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

endmodule

FILE: verif/gcr62_track_checker.sv
// Scoreboard for the GCR track formatter: mirrors the sector buffer, the registers
// and the track position, predicts every disk byte and compares it with the output.
// Depends on gcr62_pkg for the beat types and the action and register codes.
module gcr62_track_checker import gcr62_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam int unsigned DATA_START  = 14 + ADDRESS_GAP_LEN;
  localparam int unsigned FRAME_BYTES = 363 + ADDRESS_GAP_LEN + SECTOR_GAP_LEN;
  localparam int unsigned BODY_BYTES  = LEAD_GAP_LEN + SECTORS * FRAME_BYTES;
  localparam int unsigned PRINT_LIMIT = 50;

  localparam logic [POS_W-1:0] LENGTH_AFTER_RESET = POS_W'(6400);
  localparam logic [7:0]       VOLUME_AFTER_RESET = 8'd254;
  localparam logic [7:0]       FILL_BYTE          = 8'hFF;

  localparam logic [7:0] ADDR_PROLOGUE [3] = '{8'hD5, 8'hAA, 8'h96};
  localparam logic [7:0] DATA_PROLOGUE [3] = '{8'hD5, 8'hAA, 8'hAD};
  localparam logic [7:0] CLOSE_MARK    [3] = '{8'hDE, 8'hAA, 8'hEB};

  localparam logic [7:0] NIBBLE_CODE [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  localparam logic [7:0] SECTOR_SKEW [16] = '{
    8'h00, 8'h0D, 8'h0B, 8'h09, 8'h07, 8'h05, 8'h03, 8'h01,
    8'h0E, 8'h0C, 8'h0A, 8'h08, 8'h06, 8'h04, 8'h02, 8'h0F
  };

  logic [7:0]       sector_copy [4096];
  logic [POS_W-1:0] length_limit;
  logic [7:0]       volume;
  logic [7:0]       track_no;
  logic [POS_W-1:0] position;
  logic [5:0]       chain_six;
  logic             running;
  out_item_t        disk_byte_q [$];
  out_item_t        want;
  int               err_count = 0;
  int               byte_count = 0;

  task automatic report_mismatch(input string what);
    if (err_count < PRINT_LIMIT) begin
      $display("[%0t] disk byte %0d: %s", $time, byte_count, what);
    end
    err_count++;
  endtask

  // Six-bit value number i of a data field. The first 86 gather swapped bit
  // pairs from three bytes; the third byte index wraps within the sector.
  function automatic logic [5:0] six_bit_value(input logic [3:0] sec, input int unsigned i);
    logic [7:0] lo, mid, hi;
    if (i < AUX_LEN) begin
      lo  = sector_copy[{sec, 8'(i)}];
      mid = sector_copy[{sec, 8'(i + AUX_LEN)}];
      hi  = sector_copy[{sec, 8'(i + 2 * AUX_LEN)}];
      return {hi[0], hi[1], mid[0], mid[1], lo[0], lo[1]};
    end
    lo = sector_copy[{sec, 8'(i - AUX_LEN)}];
    return lo[7:2];
  endfunction

  // Address field in 4-and-4 code: odd bits first, then even bits.
  function automatic logic [7:0] address_byte(input logic [3:0] sec, input int unsigned k);
    logic [7:0] fld;
    case (k / 2)
      0:       fld = volume;
      1:       fld = track_no;
      2:       fld = SECTOR_SKEW[sec];
      default: fld = volume ^ track_no ^ SECTOR_SKEW[sec];
    endcase
    if (k % 2 == 0) fld = fld >> 1;
    return fld | 8'hAA;
  endfunction

  function automatic logic [7:0] frame_byte(input logic [3:0] sec, input int unsigned f);
    int unsigned d;
    logic [5:0]  v;
    logic [7:0]  b;
    b = FILL_BYTE;
    if (f < 3) begin
      b = ADDR_PROLOGUE[f];
    end else if (f < 11) begin
      b = address_byte(sec, f - 3);
    end else if (f < 14) begin
      b = CLOSE_MARK[f - 11];
    end else if (f < DATA_START) begin
      b = FILL_BYTE;
    end else if (f < DATA_START + 3) begin
      b = DATA_PROLOGUE[f - DATA_START];
    end else if (f < DATA_START + 3 + NIBBLE_LEN) begin
      d = f - DATA_START - 3;
      if (d == 0) chain_six = '0;
      v = six_bit_value(sec, d);
      b = NIBBLE_CODE[v ^ chain_six];
      chain_six = v;
    end else if (f == DATA_START + 3 + NIBBLE_LEN) begin
      b = NIBBLE_CODE[chain_six];
    end else if (f < DATA_START + 7 + NIBBLE_LEN) begin
      b = CLOSE_MARK[f - DATA_START - 4 - NIBBLE_LEN];
    end
    return b;
  endfunction

  task automatic pull_track_byte();
    int unsigned pos, off;
    out_item_t   r;
    pos = position;
    if (!running || pos >= length_limit) begin
      running = 1'b0;
    end else begin
      if (pos < LEAD_GAP_LEN || pos >= BODY_BYTES) begin
        r.track_byte = FILL_BYTE;
      end else begin
        off = pos - LEAD_GAP_LEN;
        r.track_byte = frame_byte(4'(off / FRAME_BYTES), off % FRAME_BYTES);
      end
      r.last_of_track = (pos + 1 >= length_limit);
      if (r.last_of_track) running = 1'b0;
      position = POS_W'(pos + 1);
      disk_byte_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_limit = LENGTH_AFTER_RESET;
      volume       = VOLUME_AFTER_RESET;
      track_no     = '0;
      position     = '0;
      chain_six    = '0;
      running      = 1'b0;
      disk_byte_q.delete();
    end else begin
      // Results leave only after their pull has been registered, so check before predicting.
      if (out_valid_i && out_ready_i) begin
        if (disk_byte_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %02h/%0b", out_data_i.track_byte,
                                    out_data_i.last_of_track));
        end else begin
          want = disk_byte_q.pop_front();
          if (out_data_i.track_byte !== want.track_byte) begin
            report_mismatch($sformatf("track_byte %02h, want %02h", out_data_i.track_byte,
                                      want.track_byte));
          end
          if (out_data_i.last_of_track !== want.last_of_track) begin
            report_mismatch($sformatf("last_of_track %0b, want %0b",
                                      out_data_i.last_of_track, want.last_of_track));
          end
        end
        byte_count++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TRACK_LENGTH:  length_limit = cfg_data_i;
          CFG_VOLUME_NUMBER: volume = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.action)
          ACT_LOAD: sector_copy[in_data_i.byte_index] = in_data_i.data_byte;
          ACT_START: begin
            track_no  = in_data_i.track_id;
            position  = '0;
            chain_six = '0;
            running   = 1'b1;
          end
          ACT_PULL: pull_track_byte();
          default: ;
        endcase
      end
    end
    errors_o  <= err_count;
    pending_o <= disk_byte_q.size();
  end

endmodule

FILE: verif/tb_gcr62_floppy_track_formatter.sv
// Testbench top for the GCR track formatter: drives loads, starts, pulls and
// register writes with random idling and gives the verdict.
// Depends on gcr62_pkg, the block and gcr62_track_checker.
module tb_gcr62_floppy_track_formatter;
  import gcr62_pkg::*;

  localparam logic [1:0]  ACT_NONE      = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RANDOM_ITEMS  = 100;
  localparam int unsigned CYCLE_LIMIT   = 200_000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int unsigned           cycle_count;
  bit                    quiet_run = 1'b0;
  bit                    hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gcr62_floppy_track_formatter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gcr62_track_checker track_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_item),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  function automatic in_item_t make_item(input logic [1:0] act);
    in_item_t it;
    it.action     = act;
    it.byte_index = ADDR_W'($urandom);
    it.data_byte  = 8'($urandom);
    it.track_id   = 8'($urandom);
    return it;
  endfunction

  // Valid stays high across back-to-back beats; within this task it only drops for an idle burst.
  task automatic send_item(input in_item_t item);
    if (!quiet_run && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pulls(input int unsigned count);
    repeat (count) send_item(make_item(ACT_PULL));
  endtask

  // Stop sending, let every predicted byte drain and give the block time to
  // finish a beat that produces nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [POS_W-1:0] len, input logic [7:0] vol);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TRACK_LENGTH;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_VOLUME_NUMBER;
    cfg_data  <= {6'($urandom), vol};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    int stall;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 17);
        repeat (stall - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_gcr62_floppy_track_formatter: errors");
    $finish;
  end

  initial begin : stimulus
    in_item_t    it;
    int unsigned n;
    int unsigned run_len;
    int unsigned pick;
    logic [1:0]  act;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short track: a pull while idle, action three, then a track that is
    // restarted and pulled past its end.
    write_settings(POS_W'(16), 8'h00);
    send_item(make_item(ACT_PULL));
    it = '1;
    send_item(it);
    it = '0;
    it.action = ACT_NONE;
    send_item(it);
    it = make_item(ACT_START);
    it.track_id = 8'hFF;
    send_item(it);
    send_pulls(5);
    // Restart in the middle of a track.
    it = make_item(ACT_START);
    it.track_id = 8'h00;
    send_item(it);
    send_pulls(18);

    // Fill sector 0 while a track is open, then run through its data field and epilogue.
    settle();
    write_settings(POS_W'(6400), 8'h00);
    it = make_item(ACT_START);
    it.track_id = 8'hFF;
    send_item(it);
    // The lead gap reads nothing from the buffer.
    send_pulls(20);
    for (int a = 0; a < SECTOR_BYTES; a++) begin
      it = make_item(ACT_LOAD);
      it.byte_index = ADDR_W'(a);
      case (a % 64)
        0:       it.data_byte = 8'h00;
        1:       it.data_byte = 8'hFF;
        default: ;
      endcase
      send_item(it);
    end
    send_pulls(401);

    settle();
    write_settings(POS_W'(16383), 8'hFF);
    n = 0;
    while (n < RANDOM_ITEMS) begin
      send_item(make_item(ACT_START));
      n++;
      run_len = $urandom_range(1, 40);
      repeat (run_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) act = ACT_PULL;
        else if (pick < 93) act = ACT_LOAD;
        else if (pick < 97) act = ACT_NONE;
        else act = ACT_START;
        send_item(make_item(act));
        n++;
      end
      if (n <= run_len + 1) begin
        // The receiver holds off while pulls keep coming, so the input stalls.
        hold_req = 1'b1;
        send_pulls(40);
        settle();
      end
    end

    // A new length below the current position ends the open track silently.
    settle();
    write_settings(POS_W'(6400), 8'($urandom));
    send_item(make_item(ACT_START));
    send_pulls(30);
    settle();
    write_settings(POS_W'(20), 8'($urandom));
    send_pulls(2);

    settle();
    write_settings(POS_W'(40), 8'd254);
    quiet_run = 1'b1;
    send_item(make_item(ACT_START));
    send_pulls(42);

    settle();
    if (errors == 0 && pending == 0) begin
      $display("tb_gcr62_floppy_track_formatter: clean");
    end else begin
      $display("tb_gcr62_floppy_track_formatter: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/gcr62_pkg.sv
sv/gcr62_sector_ram.sv
sv/gcr62_track_seq.sv
sv/gcr62_floppy_track_formatter.sv
verif/gcr62_track_checker.sv
verif/tb_gcr62_floppy_track_formatter.sv
